// ===== rtl/core/sfc_pkg.sv =====
`default_nettype none

package sfc_pkg;

	localparam int COORD_W    = 16;
	localparam int FRAC_BITS  = 14;
	// 3 products of 16x16 plus (d + r) << 14 stay within 2^32 in magnitude
	localparam int SUM_W      = 34;
	localparam int SIDE_FIRST = 2;
	localparam int PLANE_W    = 64;

	typedef logic signed [COORD_W-1:0] coord_t;

	// packed register layout: d in 63:48, nz 47:32, ny 31:16, nx 15:0
	typedef struct packed {
		coord_t d;
		coord_t nz;
		coord_t ny;
		coord_t nx;
	} plane_t;

	typedef struct packed {
		coord_t cx;
		coord_t cy;
		coord_t cz;
		coord_t r;
	} sphere_t;

endpackage

`default_nettype wire

// ===== rtl/core/sfc_plane_regs.sv =====
`default_nettype none

module sfc_plane_regs #(
	parameter int PLANE_COUNT = 6,
	parameter int ADDR_W      = 6
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [ADDR_W-1:0]           paddr,
	input  wire logic [sfc_pkg::PLANE_W-1:0] pwdata,
	output logic      [sfc_pkg::PLANE_W-1:0] prdata,
	output logic                             pready,
	output sfc_pkg::plane_t                  planes [PLANE_COUNT]
);
	import sfc_pkg::*;

	localparam int IDX_W = ADDR_W - 3;

	logic [IDX_W-1:0] idx;
	logic             wr_en;
	plane_t           plane_q [PLANE_COUNT];

	assign idx    = paddr[ADDR_W-1:3];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PLANE_COUNT; i++) begin
				plane_q[i] <= '0;
			end
		end else if (wr_en) begin
			for (int i = 0; i < PLANE_COUNT; i++) begin
				if (idx == IDX_W'(i)) begin
					plane_q[i] <= plane_t'(pwdata);
				end
			end
		end
	end

	always_comb begin
		prdata = '0;
		for (int i = 0; i < PLANE_COUNT; i++) begin
			if (idx == IDX_W'(i)) begin
				prdata = PLANE_W'(plane_q[i]);
			end
		end
	end

	assign planes = plane_q;

endmodule

`default_nettype wire

// ===== rtl/core/sfc_plane_lane.sv =====
`default_nettype none

module sfc_plane_lane (
	input  wire sfc_pkg::plane_t  plane,
	input  wire sfc_pkg::sphere_t sphere,
	output logic                  culls
);
	import sfc_pkg::*;

	logic signed [2*COORD_W-1:0] px, py, pz;
	logic signed [COORD_W:0]     dr;
	logic signed [SUM_W-1:0]     dr_ext;
	logic signed [SUM_W-1:0]     sum;

	assign px     = plane.nx * sphere.cx;
	assign py     = plane.ny * sphere.cy;
	assign pz     = plane.nz * sphere.cz;
	assign dr     = (COORD_W+1)'(plane.d) + (COORD_W+1)'(sphere.r);
	assign dr_ext = SUM_W'(dr) <<< FRAC_BITS;
	assign sum    = SUM_W'(px) + SUM_W'(py) + SUM_W'(pz) + dr_ext;

	// outside the plane when the scaled distance plus radius is negative
	assign culls = sum[SUM_W-1];

endmodule

`default_nettype wire

// ===== rtl/core/sphere_frustum_cull_test_unit.sv =====
`default_nettype none

// Sphere vs. frustum cull test.
//
// Config: APB-style port, six 64-bit plane registers at byte address 8*i.
//   Each holds nx, ny, nz (signed Q2.14) and d (signed int), low to high.
//   pready is tied high; a write lands on the access-phase edge. Reads
//   return the register; unused addresses read 0 and ignore writes.
// Input: a transfer happens on a rising edge with start high and busy low.
//   busy is never raised, so one sphere can be taken every cycle.
// Output: done pulses for one cycle with touches valid alongside it. The
//   receiver cannot stall; each result is lost if not taken that cycle.
// Pipeline: an accepted sphere passes the input register, then the result
//   register. Throughput: 1 per cycle.
//   All six plane lanes (three 16x16 multiplies and a 34-bit sum each) run
//   in parallel between the two registers, which sets the clock period.
// op = 0 tests all planes, op = 1 tests only side planes 2 and up.
// Reset: planes clear to zero (only negative radii are culled then), and
//   the pipeline empties; no result is in flight after reset.
module sphere_frustum_cull_test_unit #(
	parameter int PLANE_COUNT = 6
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// config port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [$clog2(PLANE_COUNT)+2:0] paddr,
	input  wire logic [sfc_pkg::PLANE_W-1:0] pwdata,
	output logic      [sfc_pkg::PLANE_W-1:0] prdata,
	output logic                             pready,
	// command channel
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        op,
	input  wire sfc_pkg::coord_t             center_x,
	input  wire sfc_pkg::coord_t             center_y,
	input  wire sfc_pkg::coord_t             center_z,
	input  wire sfc_pkg::coord_t             radius,
	// result channel
	output logic                             done,
	output logic                             touches
);
	import sfc_pkg::*;

	localparam int ADDR_W = $clog2(PLANE_COUNT) + 3;

	plane_t                 planes [PLANE_COUNT];
	logic                   accept;
	logic                   valid_s1;
	logic                   op_s1;
	sphere_t                sphere_s1;
	logic [PLANE_COUNT-1:0] cull_vec;
	logic [PLANE_COUNT-1:0] check_mask;
	logic                   done_q;
	logic                   touches_q;

	sfc_plane_regs #(
		.PLANE_COUNT(PLANE_COUNT),
		.ADDR_W     (ADDR_W)
	) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.planes (planes)
	);

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op;
			sphere_s1 <= '{cx: center_x, cy: center_y, cz: center_z, r: radius};
		end
	end

	// one distance test per plane, all in parallel
	for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_lane
		sfc_plane_lane u_lane (
			.plane (planes[g]),
			.sphere(sphere_s1),
			.culls (cull_vec[g])
		);
		// side-only mode skips the near and far planes
		assign check_mask[g] = !(op_s1 && (g < SIDE_FIRST));
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			touches_q <= ~|(cull_vec & check_mask);
		end
	end

	assign done    = done_q;
	assign touches = touches_q;

	// every accepted sphere reaches the lanes on the next cycle
	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted item did not reach input register");

	// no result strobe unless an item was accepted and passed the input register
	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 2))
		else $error("result strobe without an accepted item");

	// an item in flight always produces its result
	a_s1_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("item in flight lost its result");

endmodule

`default_nettype wire

// ===== test/tb_sphere_frustum_cull_test_unit.sv =====
`timescale 1ns / 100ps

module tb_sphere_frustum_cull_test_unit;

	import sfc_pkg::*;

	localparam int PLANES       = 6;
	localparam int ADDR_W       = $clog2(PLANES) + 3;
	// pipeline is two registers deep; spare settle cycles follow before touching config
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int IDLE_PCT      = 13;
	localparam int RAND_PHASES   = 7;
	localparam int PHASE_SPHERES = 150;

	// register map: plane i at byte address 8*i, index 6 is past the end
	localparam int REG_PLANE_FIRST = 0;
	localparam int REG_PLANE_LAST  = PLANES - 1;
	localparam int REG_UNUSED      = PLANES;

	// op field
	localparam logic OP_ALL   = 1'b0;
	localparam logic OP_SIDES = 1'b1;

	typedef struct packed {
		logic   op;
		coord_t cx;
		coord_t cy;
		coord_t cz;
		coord_t r;
	} sphere_cmd_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [PLANE_W-1:0] pwdata;
	logic [PLANE_W-1:0] prdata;
	logic              pready;
	logic              start;
	logic              busy;
	logic              op;
	coord_t            center_x;
	coord_t            center_y;
	coord_t            center_z;
	coord_t            radius;
	logic              done;
	logic              touches;

	// spheres waiting for the driver, and predicted answers in issue order
	sphere_cmd_t sphere_pending[$];
	logic        touch_expected[$];
	// shadow of the plane registers as the block should hold them
	logic [PLANE_W-1:0] plane_cfg [PLANES];
	logic        idle_on;
	int          fail_count;
	int          cycle_count;
	sphere_cmd_t next_sphere;

	sphere_frustum_cull_test_unit #(
		.PLANE_COUNT(PLANES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.start    (start),
		.busy     (busy),
		.op       (op),
		.center_x (center_x),
		.center_y (center_y),
		.center_z (center_z),
		.radius   (radius),
		.done     (done),
		.touches  (touches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Exact cull decision. Per plane: S = n.c + (d + r) * 2^14, culled when S < 0.
	// Worst case magnitude is 2^32, so 36 signed bits hold it with margin.
	function automatic logic sphere_touches(logic sel, coord_t cx, coord_t cy, coord_t cz,
			coord_t r);
		plane_t             pl;
		logic signed [35:0] nx, ny, nz, dr, plane_sum;
		logic               hit;
		int                 first;
		hit   = 1'b1;
		first = (sel == OP_SIDES) ? SIDE_FIRST : REG_PLANE_FIRST;
		for (int i = first; i <= REG_PLANE_LAST; i++) begin
			pl   = plane_t'(plane_cfg[i]);
			nx   = $signed(pl.nx);
			ny   = $signed(pl.ny);
			nz   = $signed(pl.nz);
			dr   = $signed(pl.d);
			dr   = dr + $signed(r);
			plane_sum = nx * $signed(cx) + ny * $signed(cy) + nz * $signed(cz)
				+ (dr <<< FRAC_BITS);
			if (plane_sum < 0)
				hit = 1'b0;
		end
		return hit;
	endfunction

	// Command driver: offers the next pending sphere whenever the slot is free,
	// predicting the answer at the edge where the transfer happens.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start    <= 1'b0;
			op       <= OP_ALL;
			center_x <= '0;
			center_y <= '0;
			center_z <= '0;
			radius   <= '0;
		end else begin
			if (start && !busy)
				touch_expected.push_back(sphere_touches(op, center_x, center_y, center_z,
					radius));
			if (!start || !busy) begin
				if (sphere_pending.size() != 0 &&
						!(idle_on && $urandom_range(99) < IDLE_PCT)) begin
					next_sphere = sphere_pending.pop_front();
					start    <= 1'b1;
					op       <= next_sphere.op;
					center_x <= next_sphere.cx;
					center_y <= next_sphere.cy;
					center_z <= next_sphere.cz;
					radius   <= next_sphere.r;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Result monitor: done is a one-cycle strobe, nothing can stall it.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (touch_expected.size() == 0) begin
				$error("touches: unexpected result, expected none, actual %0b", touches);
				fail_count++;
			end else if (touches !== touch_expected[0]) begin
				$error("touches: expected %0b, actual %0b", touch_expected[0], touches);
				fail_count++;
				void'(touch_expected.pop_front());
			end else begin
				void'(touch_expected.pop_front());
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Register write: setup cycle, then access cycle; lands on the access edge.
	task automatic plane_write(input int idx, input logic [PLANE_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx * 8);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// out-of-range index is dropped by the block
		if (idx <= REG_PLANE_LAST)
			plane_cfg[idx] = val;
	endtask

	task automatic all_planes(input logic [PLANE_W-1:0] val);
		for (int i = REG_PLANE_FIRST; i <= REG_PLANE_LAST; i++)
			plane_write(i, val);
	endtask

	task automatic add_sphere(input logic sel, input coord_t cx, input coord_t cy,
			input coord_t cz, input coord_t r);
		sphere_cmd_t s;
		s.op = sel;
		s.cx = cx;
		s.cy = cy;
		s.cz = cz;
		s.r  = r;
		sphere_pending.push_back(s);
	endtask

	// Hold off until the pipe is empty and every answer is back.
	task automatic wait_quiet();
		while (sphere_pending.size() != 0 || start || touch_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly near the origin so planes split the spheres; sometimes anywhere.
	function automatic coord_t rand_coord();
		if ($urandom_range(3) == 0)
			return coord_t'($urandom);
		return coord_t'(int'($urandom_range(4000)) - 2000);
	endfunction

	function automatic coord_t rand_radius();
		if ($urandom_range(3) == 0)
			return coord_t'($urandom);
		return coord_t'($urandom_range(3000));
	endfunction

	// Plausible frustum plane: normal within +-1.0, offset biased positive.
	function automatic logic [PLANE_W-1:0] frustum_plane();
		plane_t pl;
		pl.nx = coord_t'(int'($urandom_range(32768)) - 16384);
		pl.ny = coord_t'(int'($urandom_range(32768)) - 16384);
		pl.nz = coord_t'(int'($urandom_range(32768)) - 16384);
		pl.d  = coord_t'(int'($urandom_range(6000)) - 1000);
		return pl;
	endfunction

	initial begin
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		idle_on  = 1'b1;
		fail_count  = 0;
		cycle_count = 0;
		for (int i = 0; i < PLANES; i++)
			plane_cfg[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Planes cleared by reset: only a negative radius culls.
		add_sphere(OP_ALL, 16'sh7FFF, 16'sh8000, 16'sh7FFF, -16'sd1);
		add_sphere(OP_ALL, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sd0);
		add_sphere(OP_SIDES, 16'sd0, 16'sd0, 16'sd0, 16'sh8000);
		add_sphere(OP_SIDES, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF);
		wait_quiet();

		// Write past the last plane must leave everything untouched.
		plane_write(REG_UNUSED, {PLANE_W{1'b1}});
		add_sphere(OP_ALL, 16'sd5, 16'sd5, 16'sd5, -16'sd1);
		add_sphere(OP_ALL, 16'sd5, 16'sd5, 16'sd5, 16'sd0);
		wait_quiet();

		// Most negative normals and offsets: largest positive and negative sums.
		all_planes(64'h8000_8000_8000_8000);
		add_sphere(OP_ALL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		add_sphere(OP_ALL, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		add_sphere(OP_SIDES, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
		wait_quiet();

		// Most positive everything
		all_planes(64'h7FFF_7FFF_7FFF_7FFF);
		add_sphere(OP_ALL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		add_sphere(OP_ALL, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		add_sphere(OP_SIDES, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF);
		wait_quiet();

		// Near/far planes cull, side planes do not: op decides the answer.
		// r = 100 against d = -100 sits exactly on the plane and still touches.
		plane_write(REG_PLANE_FIRST, 64'hFF9C_0000_0000_0000);
		plane_write(REG_PLANE_FIRST + 1, 64'hFF9C_0000_0000_0000);
		for (int i = SIDE_FIRST; i <= REG_PLANE_LAST; i++)
			plane_write(i, 64'h0);
		add_sphere(OP_ALL, 16'sd0, 16'sd0, 16'sd0, 16'sd50);
		add_sphere(OP_SIDES, 16'sd0, 16'sd0, 16'sd0, 16'sd50);
		add_sphere(OP_ALL, 16'sd0, 16'sd0, 16'sd0, 16'sd100);
		add_sphere(OP_ALL, 16'sd0, 16'sd0, 16'sd0, 16'sd99);
		wait_quiet();

		// Random phases, each under its own plane set.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			for (int i = REG_PLANE_FIRST; i <= REG_PLANE_LAST; i++) begin
				case (ph)
					0: plane_write(i, {$urandom, $urandom});
					3: plane_write(i, {PLANE_W{1'b1}});
					4: plane_write(i, ($urandom_range(1) != 0) ? {$urandom, $urandom}
						: frustum_plane());
					5: plane_write(i, '0);
					default: plane_write(i, frustum_plane());
				endcase
			end
			// one long back-to-back stretch
			idle_on = (ph != 3);
			for (int n = 0; n < PHASE_SPHERES; n++) begin
				// mid-phase drain with no config change
				if (ph == 2 && n == PHASE_SPHERES / 2)
					wait_quiet();
				add_sphere($urandom_range(1) != 0 ? OP_SIDES : OP_ALL, rand_coord(),
					rand_coord(), rand_coord(), rand_radius());
			end
			wait_quiet();
		end

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
